// ----- hdl/eldcm_pkg.sv -----
// eldcm_pkg: shared types and fixed-point constants for the ECEF to local-level DCM core.
// Holds the Q30 series lane type and quadrant codes; depends on nothing.
package eldcm_pkg;

  // Q30 series arithmetic, independent of angle and coefficient widths
  localparam int TERM_W = 31;                   // series term, always below 2^31
  localparam int SQ_W   = 32;                   // x^2 in Q30, below (pi/2)^2
  localparam int SUM_W  = 33;                   // signed partial sum
  localparam int DIV_W  = TERM_W + SQ_W - 30;   // rounded product ahead of the divide
  localparam int RCP_SH = 34;                   // reciprocal scale for constant divides
  localparam int SERIES_TERMS = 8;

  localparam logic [30:0] PIO2_Q30 = 31'd1686629713;
  localparam logic [30:0] HALF_Q30 = 31'h2000_0000;
  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;

  // quadrant codes, from the top two angle bits
  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  typedef struct packed {
    logic        [TERM_W-1:0] ts;
    logic        [TERM_W-1:0] tc;
    logic signed [SUM_W-1:0]  ss;
    logic signed [SUM_W-1:0]  cs;
    logic        [SQ_W-1:0]   x2;
    logic        [1:0]        quad;
  } eldcm_lane_t;

endpackage

// ----- hdl/eldcm_series_step.sv -----
// eldcm_series_step: one Taylor term for sine and cosine in three register stages.
// Multiply by x^2, divide by a constant factorial step, accumulate. Uses eldcm_pkg.
module eldcm_series_step #(
  parameter int DS  = 6,
  parameter int DC  = 2,
  parameter bit ODD = 1'b1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_v,
  input  eldcm_pkg::eldcm_lane_t in_lane,
  output logic                   out_v,
  output eldcm_pkg::eldcm_lane_t out_lane
);

  localparam int TW = eldcm_pkg::TERM_W;
  localparam int QW = eldcm_pkg::SQ_W;
  localparam int DW = eldcm_pkg::DIV_W;
  localparam int RW = eldcm_pkg::RCP_SH;
  localparam int SW = eldcm_pkg::SUM_W;
  localparam int PA = TW + QW;
  localparam int PB = DW + RW;

  // floor(2^RW / D): quotient low by at most one, fixed in stage C
  localparam logic [63:0]   RCP_S_W = (64'd1 << RW) / 64'(DS);
  localparam logic [63:0]   RCP_C_W = (64'd1 << RW) / 64'(DC);
  localparam logic [RW-1:0] RCP_S   = RCP_S_W[RW-1:0];
  localparam logic [RW-1:0] RCP_C   = RCP_C_W[RW-1:0];
  localparam logic [DW-1:0] DS_W    = DW'(DS);
  localparam logic [DW-1:0] DC_W    = DW'(DC);

  logic v_a_r, v_b_r, v_c_r;
  eldcm_pkg::eldcm_lane_t lane_a_r, lane_b_r, lane_c_r, lane_c_nxt;
  logic [DW-1:0] d_s_a_r, d_c_a_r, d_s_b_r, d_c_b_r, q_s_b_r, q_c_b_r;
  logic [PA-1:0] p_s_nxt, p_c_nxt;
  logic [PB-1:0] r_s_nxt, r_c_nxt;
  logic [DW-1:0] qd_s, qd_c, rem_s, rem_c, t_s, t_c;

  // stage A: rounded Q30 product
  assign p_s_nxt = PA'(in_lane.ts) * PA'(in_lane.x2) + PA'(eldcm_pkg::HALF_Q30);
  assign p_c_nxt = PA'(in_lane.tc) * PA'(in_lane.x2) + PA'(eldcm_pkg::HALF_Q30);

  // stage B: reciprocal multiply
  assign r_s_nxt = PB'(d_s_a_r) * PB'(RCP_S);
  assign r_c_nxt = PB'(d_c_a_r) * PB'(RCP_C);

  // stage C: remainder correction and accumulate
  always_comb begin
    qd_s  = DW'(q_s_b_r * DS_W);
    qd_c  = DW'(q_c_b_r * DC_W);
    rem_s = d_s_b_r - qd_s;
    rem_c = d_c_b_r - qd_c;
    t_s   = q_s_b_r + DW'(rem_s >= DS_W);
    t_c   = q_c_b_r + DW'(rem_c >= DC_W);
    lane_c_nxt    = lane_b_r;
    lane_c_nxt.ts = t_s[TW-1:0];
    lane_c_nxt.tc = t_c[TW-1:0];
    if (ODD) begin
      lane_c_nxt.ss = lane_b_r.ss - $signed(SW'(t_s));
      lane_c_nxt.cs = lane_b_r.cs - $signed(SW'(t_c));
    end else begin
      lane_c_nxt.ss = lane_b_r.ss + $signed(SW'(t_s));
      lane_c_nxt.cs = lane_b_r.cs + $signed(SW'(t_c));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
    end else if (en) begin
      v_a_r <= in_v;
      v_b_r <= v_a_r;
      v_c_r <= v_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_a_r <= in_lane;
      d_s_a_r  <= p_s_nxt[PA-1:30];
      d_c_a_r  <= p_c_nxt[PA-1:30];
      lane_b_r <= lane_a_r;
      d_s_b_r  <= d_s_a_r;
      d_c_b_r  <= d_c_a_r;
      q_s_b_r  <= r_s_nxt[PB-1:RW];
      q_c_b_r  <= r_c_nxt[PB-1:RW];
      lane_c_r <= lane_c_nxt;
    end
  end

  assign out_v    = v_c_r;
  assign out_lane = lane_c_r;

endmodule

// ----- hdl/eldcm_sincos.sv -----
// eldcm_sincos: pipelined sine and cosine of a binary angle, Q1.(COEF_BITS-2) results.
// Angle scaling, x^2, eight eldcm_series_step stages, round and quadrant fold. Uses eldcm_pkg.
module eldcm_sincos #(
  parameter int ANGLE_BITS = 16,
  parameter int COEF_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_v,
  input  logic [ANGLE_BITS-1:0]       angle,
  output logic                        out_v,
  output logic signed [COEF_BITS-1:0] sin_o,
  output logic signed [COEF_BITS-1:0] cos_o
);

  localparam int N   = eldcm_pkg::SERIES_TERMS;
  localparam int SW  = eldcm_pkg::SUM_W;
  localparam int QW  = eldcm_pkg::SQ_W;
  localparam int CB  = COEF_BITS;
  localparam int F   = COEF_BITS - 2;
  localparam int SH  = 30 - F;
  localparam int RSH = 32 - ANGLE_BITS;
  localparam logic [SW:0] ONE_W = 1;
  localparam logic [SW:0] RND   = (ONE_W << SH) >> 1;
  localparam logic [SW:0] LIM   = ONE_W << F;

  function automatic logic signed [CB-1:0] to_coef(input logic signed [SW-1:0] v);
    logic [SW-1:0] mag;
    logic [SW:0]   mr;
    logic [CB-1:0] m;
    mag = v[SW-1] ? SW'(-v) : SW'(v);
    mr  = ({1'b0, mag} + RND) >> SH;
    if (mr > LIM) begin
      mr = LIM;
    end
    m = mr[CB-1:0];
    to_coef = v[SW-1] ? -$signed(m) : $signed(m);
  endfunction

  logic [29:0] r30;
  logic [60:0] xp_nxt;
  logic [61:0] x2p_nxt;
  logic        v1_r, v2_r, vo_r;
  logic [30:0] x_r;
  logic [1:0]  quad_r;
  eldcm_pkg::eldcm_lane_t lane0_r, lane0_nxt;
  eldcm_pkg::eldcm_lane_t lane_w [0:N];
  logic                   v_w    [0:N];
  logic signed [CB-1:0]   s0, c0, sin_nxt, cos_nxt;
  logic signed [CB-1:0]   sin_r, cos_r;

  // remainder within the quadrant, scaled to radians in Q30
  assign r30    = 30'(angle[ANGLE_BITS-3:0]) << RSH;
  assign xp_nxt = 61'(r30) * 61'(eldcm_pkg::PIO2_Q30) + 61'(eldcm_pkg::HALF_Q30);

  assign x2p_nxt = 62'(x_r) * 62'(x_r) + 62'(eldcm_pkg::HALF_Q30);

  always_comb begin
    lane0_nxt.ts   = x_r;
    lane0_nxt.tc   = eldcm_pkg::ONE_Q30;
    lane0_nxt.ss   = $signed(SW'(x_r));
    lane0_nxt.cs   = $signed(SW'(eldcm_pkg::ONE_Q30));
    lane0_nxt.x2   = x2p_nxt[61:62-QW];
    lane0_nxt.quad = quad_r;
  end

  assign lane_w[0] = lane0_r;
  assign v_w[0]    = v2_r;

  for (genvar k = 1; k <= N; k++) begin : g_step
    eldcm_series_step #(
      .DS  ((2 * k) * (2 * k + 1)),
      .DC  ((2 * k - 1) * (2 * k)),
      .ODD ((k % 2) == 1)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_v     (v_w[k-1]),
      .in_lane  (lane_w[k-1]),
      .out_v    (v_w[k]),
      .out_lane (lane_w[k])
    );
  end

  always_comb begin
    s0 = to_coef(lane_w[N].ss);
    c0 = to_coef(lane_w[N].cs);
    case (lane_w[N].quad)
      eldcm_pkg::QUAD_I: begin
        sin_nxt = s0;
        cos_nxt = c0;
      end
      eldcm_pkg::QUAD_II: begin
        sin_nxt = c0;
        cos_nxt = -s0;
      end
      eldcm_pkg::QUAD_III: begin
        sin_nxt = -s0;
        cos_nxt = -c0;
      end
      default: begin
        sin_nxt = -c0;
        cos_nxt = s0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      vo_r <= v_w[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r     <= xp_nxt[60:30];
      quad_r  <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
      lane0_r <= lane0_nxt;
      sin_r   <= sin_nxt;
      cos_r   <= cos_nxt;
    end
  end

  assign out_v = vo_r;
  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

// ----- hdl/eldcm_matrix.sv -----
// eldcm_matrix: forms the nine DCM elements from latitude and longitude sine and cosine.
// Two stages: raw products, then round, clamp, sign and optional transpose.
module eldcm_matrix #(
  parameter int COEF_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_v,
  input  logic                             transpose,
  input  logic signed [COEF_BITS-1:0]      sl,
  input  logic signed [COEF_BITS-1:0]      cl,
  input  logic signed [COEF_BITS-1:0]      so,
  input  logic signed [COEF_BITS-1:0]      co,
  output logic                             out_v,
  output logic [8:0][COEF_BITS-1:0]        elems
);

  localparam int CB = COEF_BITS;
  localparam int PW = 2 * COEF_BITS;
  localparam int F  = COEF_BITS - 2;
  localparam logic [PW-1:0] ONE_W = 1;
  localparam logic [PW-1:0] RND   = (ONE_W << F) >> 1;
  localparam logic [PW-1:0] LIM   = ONE_W << F;

  // minus the rounded, clamped product
  function automatic logic signed [CB-1:0] neg_qmul(input logic signed [PW-1:0] p);
    logic [PW-1:0] mag;
    logic [PW-1:0] mr;
    logic [CB-1:0] m;
    mag = p[PW-1] ? PW'(-p) : PW'(p);
    mr  = (mag + RND) >> F;
    if (mr > LIM) begin
      mr = LIM;
    end
    m = mr[CB-1:0];
    neg_qmul = p[PW-1] ? $signed(m) : -$signed(m);
  endfunction

  logic v1_r, v2_r;
  logic signed [PW-1:0] p_cosl_r, p_slso_r, p_clco_r, p_clso_r;
  logic signed [CB-1:0] sl_r, cl_r, so_r, co_r;
  logic signed [CB-1:0] m [0:8];
  logic [8:0][CB-1:0]   elems_nxt, elems_r;

  always_comb begin
    m[0] = neg_qmul(p_cosl_r);
    m[1] = neg_qmul(p_slso_r);
    m[2] = cl_r;
    m[3] = -so_r;
    m[4] = co_r;
    m[5] = '0;
    m[6] = neg_qmul(p_clco_r);
    m[7] = neg_qmul(p_clso_r);
    m[8] = -sl_r;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        elems_nxt[i*3+j] = transpose ? m[j*3+i] : m[i*3+j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_cosl_r <= PW'(co) * PW'(sl);
      p_slso_r <= PW'(sl) * PW'(so);
      p_clco_r <= PW'(cl) * PW'(co);
      p_clso_r <= PW'(cl) * PW'(so);
      sl_r     <= sl;
      cl_r     <= cl;
      so_r     <= so;
      co_r     <= co;
      elems_r  <= elems_nxt;
    end
  end

  assign out_v = v2_r;
  assign elems = elems_r;

endmodule

// ----- hdl/ecef_to_local_level_dcm_core.sv -----
// ecef_to_local_level_dcm_core: latitude/longitude to ECEF-to-NED direction cosine matrix.
// Pipeline: 30 register stages (27 sine/cosine, two matrix, the output register); the first
//   is loaded by the input transfer edge, and out_valid rises as the last one loads.
// Throughput: one transfer per cycle unless in_stall; up to 31 items in flight (30 stages
//   plus the skid); in_stall is set as the skid fills and clears the cycle after out_stall drops.
// Reset (rst_n low at a clock edge) empties the pipeline and clears transpose_output to 0.
module ecef_to_local_level_dcm_core #(
  parameter int ANGLE_BITS = 16,
  parameter int COEF_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [ANGLE_BITS-1:0] in_latitude_angle,
  input  logic signed [ANGLE_BITS-1:0] in_longitude_angle,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [COEF_BITS-1:0] out_elem_00,
  output logic signed [COEF_BITS-1:0] out_elem_01,
  output logic signed [COEF_BITS-1:0] out_elem_02,
  output logic signed [COEF_BITS-1:0] out_elem_10,
  output logic signed [COEF_BITS-1:0] out_elem_11,
  output logic signed [COEF_BITS-1:0] out_elem_12,
  output logic signed [COEF_BITS-1:0] out_elem_20,
  output logic signed [COEF_BITS-1:0] out_elem_21,
  output logic signed [COEF_BITS-1:0] out_elem_22,
  // configuration write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_transpose_output
);

  // The whole pipeline moves together under pipe_en. A skid register behind the output
  // register catches the one result that is already leaving the pipeline when the
  // consumer stalls, so in_stall comes straight from a flop and no transfer is lost.

  logic pipe_en;
  logic in_xfer;
  logic transpose_r;

  logic                        lat_v, lon_v;
  logic signed [COEF_BITS-1:0] sl, cl, so, co;
  logic                        mat_v;
  logic [8:0][COEF_BITS-1:0]   mat_data;

  logic                        out_v_r, out_v_nxt;
  logic                        skid_v_r, skid_v_nxt;
  logic [8:0][COEF_BITS-1:0]   out_data_r, out_data_nxt;
  logic [8:0][COEF_BITS-1:0]   skid_data_r, skid_data_nxt;
  logic                        out_free;

  assign pipe_en  = !skid_v_r;
  assign in_stall = skid_v_r;
  assign in_xfer  = in_valid && !in_stall;

  // config register; the user must write it only while no item is in flight (not enforced here)
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      transpose_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      transpose_r <= cfg_transpose_output;
    end
  end

  // sine/cosine of both angles run side by side with identical latency
  eldcm_sincos #(
    .ANGLE_BITS (ANGLE_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_lat (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (pipe_en),
    .in_v  (in_xfer),
    .angle ($unsigned(in_latitude_angle)),
    .out_v (lat_v),
    .sin_o (sl),
    .cos_o (cl)
  );

  eldcm_sincos #(
    .ANGLE_BITS (ANGLE_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_lon (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (pipe_en),
    .in_v  (in_xfer),
    .angle ($unsigned(in_longitude_angle)),
    .out_v (lon_v),
    .sin_o (so),
    .cos_o (co)
  );

  eldcm_matrix #(
    .COEF_BITS (COEF_BITS)
  ) u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_v      (lat_v && lon_v),
    .transpose (transpose_r),
    .sl        (sl),
    .cl        (cl),
    .so        (so),
    .co        (co),
    .out_v     (mat_v),
    .elems     (mat_data)
  );

  // output register plus skid
  assign out_free = !out_v_r || !out_stall;

  always_comb begin
    out_v_nxt     = out_v_r;
    out_data_nxt  = out_data_r;
    skid_v_nxt    = skid_v_r;
    skid_data_nxt = skid_data_r;
    if (out_free) begin
      if (skid_v_r) begin
        // drain skid first; pipeline is frozen this cycle
        out_v_nxt    = 1'b1;
        out_data_nxt = skid_data_r;
        skid_v_nxt   = 1'b0;
      end else begin
        out_v_nxt    = mat_v;
        out_data_nxt = mat_data;
      end
    end else if (mat_v && pipe_en) begin
      // output held: park the result leaving the pipeline
      skid_v_nxt    = 1'b1;
      skid_data_nxt = mat_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid   = out_v_r;
  assign out_elem_00 = $signed(out_data_r[0]);
  assign out_elem_01 = $signed(out_data_r[1]);
  assign out_elem_02 = $signed(out_data_r[2]);
  assign out_elem_10 = $signed(out_data_r[3]);
  assign out_elem_11 = $signed(out_data_r[4]);
  assign out_elem_12 = $signed(out_data_r[5]);
  assign out_elem_20 = $signed(out_data_r[6]);
  assign out_elem_21 = $signed(out_data_r[7]);
  assign out_elem_22 = $signed(out_data_r[8]);

endmodule

// ----- tb/sv/ecef_to_local_level_dcm_core_test.sv -----
// ecef_to_local_level_dcm_core_test: self-checking bench for the ECEF to local-level DCM core.
// Predicts every matrix from the angle pair with a bit-exact fixed-point series model.
// Depends on eldcm_pkg (quadrant codes) and ecef_to_local_level_dcm_core.
`timescale 1ns / 1ps

module ecef_to_local_level_dcm_core_test;

  localparam int ANGLE_W   = 16;
  localparam int ELEM_W    = 16;
  localparam int FRAC_Q    = ELEM_W - 2;          // Q1.14 elements
  localparam int SERIES_N  = 8;                   // sine to x^17, cosine to x^16
  localparam int PIPE_LAT  = 29;                  // input transfer to out_valid, in clock edges
  localparam int MAX_WAIT  = 17;                  // longest gap / stall drawn per item

  localparam logic [63:0] RAD_HALF_PI = 64'd1686629713;  // pi/2 in Q30
  localparam logic [63:0] RND_Q30     = 64'd1 << 29;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam longint      UNITY_Q14   = 64'sd1 << FRAC_Q;

  // nine elements, index row*3 + col
  typedef logic [8:0][ELEM_W-1:0] dcm_t;

  logic clk;
  logic rst_n;

  logic                      in_valid;
  logic                      in_stall;
  logic signed [ANGLE_W-1:0] in_latitude_angle;
  logic signed [ANGLE_W-1:0] in_longitude_angle;

  logic                      out_valid;
  logic                      out_stall;
  logic signed [ELEM_W-1:0]  out_elem_00, out_elem_01, out_elem_02;
  logic signed [ELEM_W-1:0]  out_elem_10, out_elem_11, out_elem_12;
  logic signed [ELEM_W-1:0]  out_elem_20, out_elem_21, out_elem_22;

  logic                      cfg_valid;
  logic                      cfg_ready;
  logic                      cfg_transpose_output;

  dcm_t got_dcm;
  assign got_dcm = {out_elem_22, out_elem_21, out_elem_20,
                    out_elem_12, out_elem_11, out_elem_10,
                    out_elem_02, out_elem_01, out_elem_00};

  // mirror of the register, updated at the config transfer
  logic transpose_sel;
  dcm_t dcm_expected_q[$];
  int   mismatch_count;

  // idle-free stretches, one counter per side
  int   in_calm_left;
  int   out_calm_left;

  ecef_to_local_level_dcm_core #(
    .ANGLE_BITS(ANGLE_W),
    .COEF_BITS (ELEM_W)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_latitude_angle   (in_latitude_angle),
    .in_longitude_angle  (in_longitude_angle),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_elem_00         (out_elem_00),
    .out_elem_01         (out_elem_01),
    .out_elem_02         (out_elem_02),
    .out_elem_10         (out_elem_10),
    .out_elem_11         (out_elem_11),
    .out_elem_12         (out_elem_12),
    .out_elem_20         (out_elem_20),
    .out_elem_21         (out_elem_21),
    .out_elem_22         (out_elem_22),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_transpose_output(cfg_transpose_output)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------

  // Round magnitude to nearest (ties away from zero) after a right shift,
  // then saturate to +/-1.0 in Q1.14.
  function automatic longint round_sat_q14(input longint v, input int sh);
    logic            neg;
    longint unsigned mag;
    neg = (v < 0);
    mag = neg ? -v : v;
    if (sh > 0)
      mag = (mag + (64'd1 << (sh - 1))) >> sh;
    if (mag > UNITY_Q14)
      mag = UNITY_Q14;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint mul_q14(input longint a, input longint b);
    return round_sat_q14(a * b, FRAC_Q);
  endfunction

  // Quadrant from the top two bits, series on the remainder scaled to Q30 radians.
  function automatic void sincos_q14(input logic [ANGLE_W-1:0] angle,
                                     output longint sin_v, output longint cos_v);
    logic [63:0] x, x2, ts, tc;
    longint      ss, cs, s0, c0;
    x  = ((64'(angle[ANGLE_W-3:0]) << (32 - ANGLE_W)) * RAD_HALF_PI + RND_Q30) >> 30;
    x2 = (x * x + RND_Q30) >> 30;
    ts = x;
    tc = ONE_Q30;
    ss = longint'(x);
    cs = longint'(ONE_Q30);
    for (int k = 1; k <= SERIES_N; k++) begin
      // products round, factorial steps truncate
      ts = ((ts * x2 + RND_Q30) >> 30) / 64'((2 * k) * (2 * k + 1));
      tc = ((tc * x2 + RND_Q30) >> 30) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        ss -= longint'(ts);
        cs -= longint'(tc);
      end else begin
        ss += longint'(ts);
        cs += longint'(tc);
      end
    end
    s0 = round_sat_q14(ss, 30 - FRAC_Q);
    c0 = round_sat_q14(cs, 30 - FRAC_Q);
    case (angle[ANGLE_W-1:ANGLE_W-2])
      eldcm_pkg::QUAD_I: begin
        sin_v = s0;
        cos_v = c0;
      end
      eldcm_pkg::QUAD_II: begin
        sin_v = c0;
        cos_v = -s0;
      end
      eldcm_pkg::QUAD_III: begin
        sin_v = -s0;
        cos_v = -c0;
      end
      default: begin
        sin_v = -c0;
        cos_v = s0;
      end
    endcase
  endfunction

  function automatic dcm_t predict_dcm(input logic [ANGLE_W-1:0] lat,
                                       input logic [ANGLE_W-1:0] lon,
                                       input logic transposed);
    longint sin_lat, cos_lat, sin_lon, cos_lon;
    longint m [0:2][0:2];
    dcm_t   d;
    sincos_q14(lat, sin_lat, cos_lat);
    sincos_q14(lon, sin_lon, cos_lon);
    m[0][0] = -mul_q14(cos_lon, sin_lat);
    m[0][1] = -mul_q14(sin_lat, sin_lon);
    m[0][2] = cos_lat;
    m[1][0] = -sin_lon;
    m[1][1] = cos_lon;
    m[1][2] = 0;
    m[2][0] = -mul_q14(cos_lat, cos_lon);
    m[2][1] = -mul_q14(cos_lat, sin_lon);
    m[2][2] = -sin_lat;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        d[r * 3 + c] = ELEM_W'(transposed ? m[c][r] : m[r][c]);
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake helpers
  // ---------------------------------------------------------------------------

  // 0..MAX_WAIT idle cycles, except inside an idle-free stretch
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // One angle-pair transfer. Entered right after a rising edge; valid stays
  // high into the next call when no gap is drawn.
  task automatic send_angles(input logic [ANGLE_W-1:0] lat, input logic [ANGLE_W-1:0] lon);
    int gap;
    gap = draw_wait(in_calm_left);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_latitude_angle  <= lat;
    in_longitude_angle <= lon;
    do @(posedge clk); while (in_stall);
    dcm_expected_q.insert(dcm_expected_q.size(), predict_dcm(lat, lon, transpose_sel));
  endtask

  // Stop sending and wait for every predicted matrix to come out.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    do @(posedge clk); while (dcm_expected_q.size() != 0);
  endtask

  // Register write; only issued with the pipeline empty.
  task automatic write_transpose(input logic sel);
    cfg_valid            <= 1'b1;
    cfg_transpose_output <= sel;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    transpose_sel  = sel;
  endtask

  // Latitude: mostly within +/-pi/2, some around the poles and equator,
  // some past the poles.
  function automatic logic [ANGLE_W-1:0] random_latitude();
    case ($urandom_range(0, 9))
      0:       return ANGLE_W'($urandom);
      1, 2:    return ANGLE_W'($urandom_range(0, 2) * 16384 - 16384 + $urandom_range(0, 6) - 3);
      default: return ANGLE_W'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  // Longitude: full circle, with extra weight on quadrant boundaries.
  function automatic logic [ANGLE_W-1:0] random_longitude();
    if ($urandom_range(0, 4) == 0)
      return ANGLE_W'($urandom_range(0, 3) * 16384 + $urandom_range(0, 6) - 3);
    return ANGLE_W'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: per-transfer stall draw, and the checker
  // ---------------------------------------------------------------------------

  initial begin : result_stall
    int hold;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      hold = draw_wait(out_calm_left);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin : check_results
    dcm_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (dcm_expected_q.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result transfer with no matrix pending", $time);
      end else begin
        want = dcm_expected_q.pop_front();
        for (int e = 0; e < 9; e++) begin
          if (got_dcm[e] !== want[e]) begin
            // keep the log short on a systematic error
            if (mismatch_count < 40)
              $display("%0t ns: elem_%0d%0d expected %0d, actual %0d", $time, e / 3, e % 3,
                       $signed(want[e]), $signed(got_dcm[e]));
            mismatch_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Poles, equator, date line, quadrant edges, the largest series remainder,
  // latitudes past the poles. Runs with the register as it stands (reset value on the first run).
  task automatic test_directed_angles(input int count);
    int lat_pts [20] = '{0, 16384, -16384, 16384, -16384, 8192, -8192, 16383, -16383, 1,
                         -1, 8192, -8192, 32767, -32768, 20000, -20000, 5461, 16384, 4096};
    int lon_pts [20] = '{0, 0, 0, 32767, -32768, 8192, -8192, 16383, -16385, -1,
                         1, 16384, -16384, 12345, -32768, 24576, -24576, 10923, 16384, -28672};
    for (int i = 0; i < count; i++)
      send_angles(ANGLE_W'(lat_pts[i]), ANGLE_W'(lon_pts[i]));
    drain_pipeline();
  endtask

  // The first 12 of the same corner points with the transposed (local level to ECEF) output.
  task automatic test_transposed_corners();
    write_transpose(1'b1);
    test_directed_angles(12);
  endtask

  // One register setting, then a stream of random angle pairs.
  task automatic test_random_stream(input logic sel, input int n_items);
    write_transpose(sel);
    repeat (n_items) send_angles(random_latitude(), random_longitude());
    drain_pipeline();
  endtask

  initial begin : time_limit
    #5_000_000;
    $display("ecef_to_local_level_dcm_core_test: FAIL");
    $finish;
  end

  initial begin : run_tests
    mismatch_count        = 0;
    in_calm_left          = 0;
    out_calm_left         = 0;
    transpose_sel         = 1'b0;          // register reset value
    rst_n                <= 1'b0;
    in_valid             <= 1'b0;
    in_latitude_angle    <= '0;
    in_longitude_angle   <= '0;
    cfg_valid            <= 1'b0;
    cfg_transpose_output <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_angles(20);
    test_transposed_corners();
    test_random_stream(1'b0, 125);
    test_random_stream(1'b1, 125);
    test_random_stream(1'b1, 125);
    test_random_stream(1'b0, 125);
    test_random_stream(1'b1, 125);

    // nothing pending; let any stray transfer show up
    repeat (PIPE_LAT + 2 * MAX_WAIT) @(posedge clk);
    if (mismatch_count == 0 && dcm_expected_q.size() == 0) begin
      $display("ecef_to_local_level_dcm_core_test: PASS");
    end else begin
      $display("ecef_to_local_level_dcm_core_test: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/eldcm_pkg.sv
hdl/eldcm_series_step.sv
hdl/eldcm_sincos.sv
hdl/eldcm_matrix.sv
hdl/ecef_to_local_level_dcm_core.sv
tb/sv/ecef_to_local_level_dcm_core_test.sv
